[src/integer_iir_filter_unit_defines.svh]
// Assertion macros shared by the filter modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef INTEGER_IIR_FILTER_UNIT_DEFINES_SVH
`define INTEGER_IIR_FILTER_UNIT_DEFINES_SVH

`define IIRF_IMPL(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`define IIRF_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[src/iirf_pkg.sv]
`default_nettype none

package iirf_pkg;

	localparam int DATA_W    = 16;
	localparam int A0_W      = 15;
	localparam int DIGIT_W   = 2;
	localparam int MAC_STEPS = DATA_W / DIGIT_W;
	localparam int DIV_STEPS = DATA_W;
	localparam int REG_TAPS  = 4;
	localparam int ADDR_W    = 5;
	localparam int IDX_W     = 3;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [DATA_W-1:0]        word_t;
	typedef logic [A0_W-1:0]          div_t;
	typedef logic [IDX_W-1:0]         reg_idx_t;

	localparam reg_idx_t REG_B0 = 3'd0;
	localparam reg_idx_t REG_B1 = 3'd1;
	localparam reg_idx_t REG_B2 = 3'd2;
	localparam reg_idx_t REG_B3 = 3'd3;
	localparam reg_idx_t REG_A0 = 3'd4;
	localparam reg_idx_t REG_A1 = 3'd5;
	localparam reg_idx_t REG_A2 = 3'd6;
	localparam reg_idx_t REG_A3 = 3'd7;

	// Product of a coefficient and one two-bit digit, modulo 2^16.
	function automatic word_t mul_digit(input word_t coef, input logic [DIGIT_W-1:0] dig);
		word_t prod;
		begin
			prod = dig[0] ? coef : '0;
			if (dig[1]) begin
				prod = prod + {coef[DATA_W-2:0], 1'b0};
			end
			return prod;
		end
	endfunction

endpackage

`default_nettype wire

[src/iirf_div.sv]
`default_nettype none

`include "integer_iir_filter_unit_defines.svh"

module iirf_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire iirf_pkg::word_t  acc,
	input  wire iirf_pkg::div_t   coef_a0,
	output logic                  done,
	output iirf_pkg::word_t       quotient
);

	localparam int CNT_W = $clog2(iirf_pkg::DIV_STEPS);
	localparam int W     = iirf_pkg::DATA_W;
	localparam int DW    = iirf_pkg::A0_W;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	iirf_pkg::word_t  dq_q;
	logic [DW-1:0]    rem_q;

	logic [W:0]       num;
	iirf_pkg::word_t  mag;
	logic [DW-1:0]    divisor;
	logic [W-1:0]     rshift;
	logic [W-1:0]     rdiff;
	logic             ge;

	// The numerator adds half the divisor before the quotient is truncated toward zero.
	assign num     = {acc[W-1], acc} + {2'b00, coef_a0[DW-1:1]};
	assign mag     = num[W] ? W'(-num) : num[W-1:0];
	assign divisor = (coef_a0 == '0) ? DW'(1) : coef_a0;
	assign rshift  = {rem_q, dq_q[W-1]};
	assign rdiff   = rshift - {1'b0, divisor};
	assign ge      = rshift >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[W];
			dq_q  <= mag;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rdiff[DW-1:0] : rshift[DW-1:0];
			dq_q  <= {dq_q[W-2:0], ge};
		end
	end

	assign done     = busy_q && (cnt_q == CNT_W'(iirf_pkg::DIV_STEPS - 1));
	assign quotient = neg_q ? W'(-dq_q) : dq_q;

	`IIRF_NEXT(a_start_busy, start, busy_q, "Divider did not start.")
	`IIRF_IMPL(a_start_idle, start, !busy_q, "Divider restarted while busy.")
	`IIRF_NEXT(a_done_idle, done, !busy_q, "Divider stayed busy after its last step.")

endmodule

`default_nettype wire

[src/integer_iir_filter_unit.sv]
// Integer IIR filter, direct form I, four feedforward and three feedback taps.
// Input channel: sample_in and restart, with in_valid and in_stall. A beat is
// taken when in_valid is high and in_stall is low. A set restart clears both
// sample histories before the beat is used.
// Output channel: sample_out with out_valid and out_stall, one beat per input.
// Coefficients are written over the APB port; the user must do so only while
// the filter is idle, as the block itself does not enforce it. Each beat runs
// through the MAC, START, DIV and DONE states in order: two-bit digit
// multiply-accumulate over all taps at once, the start of the divider,
// bit-serial restoring division by coef_a0, and the load of the output
// register. A new input is taken only once the beat has returned to idle.
// The output register lets the next input be taken while a result waits.
// If the receiver stalls, the finished result holds in its final cycle until
// the output register is free, and no further input is taken.
// Reset clears the histories, sets coef_b0 and coef_a0 to one and the other
// coefficients to zero, and empties the output register.
`default_nettype none

`include "integer_iir_filter_unit_defines.svh"

module integer_iir_filter_unit #(
	parameter int TAPS = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [15:0]           sample_in,
	input  wire logic                         restart,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [15:0]                sample_out,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [iirf_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int W      = iirf_pkg::DATA_W;
	localparam int DG     = iirf_pkg::DIGIT_W;
	localparam int NT     = (TAPS < iirf_pkg::REG_TAPS) ? TAPS : iirf_pkg::REG_TAPS;
	localparam int HIST   = NT - 1;
	localparam int HIST_D = (HIST > 0) ? HIST : 1;
	localparam int CNT_W  = $clog2(iirf_pkg::MAC_STEPS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAC   = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	iirf_pkg::word_t  coef_b_q [0:3];
	iirf_pkg::word_t  coef_a_q [0:2];
	iirf_pkg::div_t   coef_a0_q;

	iirf_pkg::word_t  x_q;
	iirf_pkg::word_t  xh_q [0:HIST_D-1];
	iirf_pkg::word_t  yh_q [0:HIST_D-1];
	iirf_pkg::word_t  acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       state_q;
	logic             out_valid_q;
	iirf_pkg::word_t  out_q;

	logic               in_take;
	logic               out_free;
	logic               cfg_wr;
	iirf_pkg::reg_idx_t cfg_idx;
	iirf_pkg::word_t    digit_sum;
	logic               div_start;
	logic               div_done;
	iirf_pkg::word_t    quotient;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = paddr[iirf_pkg::ADDR_W-1:2];
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b_q[0] <= 16'd1;
			coef_b_q[1] <= '0;
			coef_b_q[2] <= '0;
			coef_b_q[3] <= '0;
			coef_a_q[0] <= '0;
			coef_a_q[1] <= '0;
			coef_a_q[2] <= '0;
			coef_a0_q   <= 15'd1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				iirf_pkg::REG_B0: coef_b_q[0] <= pwdata[W-1:0];
				iirf_pkg::REG_B1: coef_b_q[1] <= pwdata[W-1:0];
				iirf_pkg::REG_B2: coef_b_q[2] <= pwdata[W-1:0];
				iirf_pkg::REG_B3: coef_b_q[3] <= pwdata[W-1:0];
				iirf_pkg::REG_A0: coef_a0_q   <= pwdata[iirf_pkg::A0_W-1:0];
				iirf_pkg::REG_A1: coef_a_q[0] <= pwdata[W-1:0];
				iirf_pkg::REG_A2: coef_a_q[1] <= pwdata[W-1:0];
				iirf_pkg::REG_A3: coef_a_q[2] <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			iirf_pkg::REG_B0: prdata = {{16{coef_b_q[0][W-1]}}, coef_b_q[0]};
			iirf_pkg::REG_B1: prdata = {{16{coef_b_q[1][W-1]}}, coef_b_q[1]};
			iirf_pkg::REG_B2: prdata = {{16{coef_b_q[2][W-1]}}, coef_b_q[2]};
			iirf_pkg::REG_B3: prdata = {{16{coef_b_q[3][W-1]}}, coef_b_q[3]};
			iirf_pkg::REG_A0: prdata = {17'd0, coef_a0_q};
			iirf_pkg::REG_A1: prdata = {{16{coef_a_q[0][W-1]}}, coef_a_q[0]};
			iirf_pkg::REG_A2: prdata = {{16{coef_a_q[1][W-1]}}, coef_a_q[1]};
			iirf_pkg::REG_A3: prdata = {{16{coef_a_q[2][W-1]}}, coef_a_q[2]};
			default:          prdata = '0;
		endcase
	end

	// Top digit of every operand, all taps summed in one step of the Horner form.
	always_comb begin
		digit_sum = iirf_pkg::mul_digit(coef_b_q[0], x_q[W-1:W-DG]);
		for (int j = 0; j < HIST_D; j++) begin
			if (j < HIST) begin
				digit_sum = digit_sum
					+ iirf_pkg::mul_digit(coef_b_q[j+1], xh_q[j][W-1:W-DG])
					- iirf_pkg::mul_digit(coef_a_q[j], yh_q[j][W-1:W-DG]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < HIST_D; j++) begin
				xh_q[j] <= '0;
				yh_q[j] <= '0;
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_MAC;
						cnt_q   <= '0;
						if (restart) begin
							for (int j = 0; j < HIST_D; j++) begin
								xh_q[j] <= '0;
								yh_q[j] <= '0;
							end
						end
					end
				end
				ST_MAC: begin
					cnt_q <= cnt_q + 1'b1;
					for (int j = 0; j < HIST_D; j++) begin
						xh_q[j] <= {xh_q[j][W-DG-1:0], xh_q[j][W-1:W-DG]};
						yh_q[j] <= {yh_q[j][W-DG-1:0], yh_q[j][W-1:W-DG]};
					end
					if (cnt_q == CNT_W'(iirf_pkg::MAC_STEPS - 1)) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						xh_q[0]     <= x_q;
						yh_q[0]     <= quotient;
						for (int j = 1; j < HIST_D; j++) begin
							xh_q[j] <= xh_q[j-1];
							yh_q[j] <= yh_q[j-1];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q   <= sample_in;
			acc_q <= '0;
		end else if (state_q == ST_MAC) begin
			x_q   <= {x_q[W-DG-1:0], x_q[W-1:W-DG]};
			acc_q <= {acc_q[W-DG-1:0], {DG{1'b0}}} + digit_sum;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= quotient;
		end
	end

	assign div_start = (state_q == ST_START);

	iirf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.acc      (acc_q),
		.coef_a0  (coef_a0_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	`IIRF_NEXT(a_take_starts, in_take, state_q == ST_MAC, "Accepted beat did not start work.")
	`IIRF_IMPL(a_done_in_div, div_done, state_q == ST_DIV, "Divider finished outside its phase.")
	`IIRF_NEXT(a_done_emits, state_q == ST_DONE && out_free,
		out_valid_q && state_q == ST_IDLE, "Finished result was not loaded.")

endmodule

`default_nettype wire
